### rtl/core/stnl_pkg.sv
// ----------------------------------------------------------------------------
// stnl_pkg
// Shared types and constants for the nearest-entry sensor table linearizer.
// ----------------------------------------------------------------------------
package stnl_pkg;

  localparam int TEMP_W   = 9;
  localparam int MV_W     = 12;
  localparam int SAMPLE_W = 10;
  localparam int OUT_W    = 10;
  localparam int ENT_W    = 9;
  localparam int IDX_W    = 8;
  localparam int ENTRY_W  = TEMP_W + MV_W;

  // mv = floor(sample * 3.223), done as a multiply by 3.223 * 2^24 rounded up
  localparam int MV_MUL_W               = 26;
  localparam logic [MV_MUL_W-1:0] MV_MUL = 26'd54072968;
  localparam int MV_SHIFT               = 24;
  localparam int MV_PROD_W              = MV_MUL_W + SAMPLE_W;

  // x / 5 for x below 16384, done as (x * 6554) >> 15
  localparam int DIV5_IN_W                = 12;
  localparam int DIV5_MUL_W               = 13;
  localparam logic [DIV5_MUL_W-1:0] DIV5_MUL = 13'd6554;
  localparam int DIV5_SHIFT               = 15;
  localparam int DIV5_PROD_W              = DIV5_IN_W + DIV5_MUL_W;

  localparam logic signed [OUT_W:0] F_OFFSET = 11'sd32;

  localparam logic [ENT_W-1:0] ENTRIES_RESET = 9'd201;
  localparam logic UNIT_RESET = 1'b0;
  localparam logic UNIT_FAHRENHEIT = 1'b0;

  // register index, taken from paddr[2]
  localparam logic REG_UNIT    = 1'b0;
  localparam logic REG_ENTRIES = 1'b1;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_CONVERT = 1'b1;

  typedef struct packed {
    logic capture;
    logic scale;
    logic init;
    logic search;
    logic nb_low;
    logic nb_high;
    logic pick;
    logic fmul;
    logic fout;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic search_end;
  } sts_t;

endpackage

### rtl/core/stnl_ram.sv
// ----------------------------------------------------------------------------
// stnl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stnl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/stnl_ctrl.sv
// ----------------------------------------------------------------------------
// stnl_ctrl
// Sequencer for one convert: scale, binary search, neighbor check, units.
// ----------------------------------------------------------------------------
module stnl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          kind,
  input  stnl_pkg::sts_t sts,
  output stnl_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SCALE   = 4'd1;
  localparam logic [3:0] S_INIT    = 4'd2;
  localparam logic [3:0] S_SEARCH  = 4'd3;
  localparam logic [3:0] S_NB_LOW  = 4'd4;
  localparam logic [3:0] S_NB_HIGH = 4'd5;
  localparam logic [3:0] S_PICK    = 4'd6;
  localparam logic [3:0] S_FMUL    = 4'd7;
  localparam logic [3:0] S_FOUT    = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start && kind == stnl_pkg::KIND_CONVERT) begin
          state_next = S_SCALE;
        end
      end
      S_SCALE:   state_next = S_INIT;
      S_INIT:    state_next = S_SEARCH;
      S_SEARCH: begin
        if (sts.hit) begin
          state_next = S_FMUL;
        end else if (sts.search_end) begin
          state_next = S_NB_LOW;
        end
      end
      S_NB_LOW:  state_next = S_NB_HIGH;
      S_NB_HIGH: state_next = S_PICK;
      S_PICK:    state_next = S_FMUL;
      S_FMUL:    state_next = S_FOUT;
      S_FOUT:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_FOUT);
    end
  end

  assign busy        = (state != S_IDLE);
  assign cmd.capture = (state == S_IDLE) && start && (kind == stnl_pkg::KIND_CONVERT);
  assign cmd.scale   = (state == S_SCALE);
  assign cmd.init    = (state == S_INIT);
  assign cmd.search  = (state == S_SEARCH);
  assign cmd.nb_low  = (state == S_NB_LOW);
  assign cmd.nb_high = (state == S_NB_HIGH);
  assign cmd.pick    = (state == S_PICK);
  assign cmd.fmul    = (state == S_FMUL);
  assign cmd.fout    = (state == S_FOUT);

endmodule

### rtl/core/stnl_datapath.sv
// ----------------------------------------------------------------------------
// stnl_datapath
// Millivolt scaling, search pointers, neighbor compare and unit conversion.
// ----------------------------------------------------------------------------
module stnl_datapath #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                                 clk,
  input  stnl_pkg::cmd_t                       cmd,
  input  logic                                 unit_select,
  input  logic [stnl_pkg::ENT_W-1:0]           entries_in_use,
  input  logic [stnl_pkg::SAMPLE_W-1:0]        adc_sample,
  output stnl_pkg::sts_t                       sts,
  output logic [$clog2(TABLE_DEPTH)-1:0]       ram_raddr,
  input  logic [stnl_pkg::ENTRY_W-1:0]         ram_rdata,
  output logic signed [stnl_pkg::OUT_W-1:0]    temperature
);

  localparam int AW = $clog2(TABLE_DEPTH);
  // signed pointer width: holds the entry count and minus one
  localparam int CW = ((AW > stnl_pkg::ENT_W) ? AW : stnl_pkg::ENT_W) + 2;
  localparam logic signed [CW-1:0] ONE  = CW'(1);
  localparam logic signed [CW-1:0] ZERO = '0;
  localparam logic signed [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  logic [stnl_pkg::SAMPLE_W-1:0]  sample;
  logic [stnl_pkg::MV_PROD_W-1:0] mv_prod;
  logic [stnl_pkg::MV_W-1:0]      mv;

  logic signed [CW-1:0] n_c;
  logic signed [CW-1:0] n_m1;
  logic signed [CW-1:0] lo;
  logic signed [CW-1:0] hi;
  logic signed [CW-1:0] mid;
  logic signed [CW-1:0] lo_next;
  logic signed [CW-1:0] hi_next;
  logic signed [CW-1:0] mid_next;
  logic signed [CW-1:0] below;
  logic signed [CW-1:0] above;
  logic signed [CW-1:0] first_mid;

  logic [stnl_pkg::MV_W-1:0]          rd_mv;
  logic signed [stnl_pkg::TEMP_W-1:0] rd_t;
  logic                               rd_gt;

  logic [stnl_pkg::MV_W-1:0]          c_mv;
  logic [stnl_pkg::MV_W-1:0]          l_mv;
  logic [stnl_pkg::MV_W-1:0]          h_mv;
  logic signed [stnl_pkg::TEMP_W-1:0] c_t;
  logic signed [stnl_pkg::TEMP_W-1:0] l_t;
  logic signed [stnl_pkg::TEMP_W-1:0] h_t;
  logic signed [stnl_pkg::TEMP_W-1:0] t_sel;
  logic signed [stnl_pkg::TEMP_W-1:0] t_pick;

  logic [stnl_pkg::MV_W-1:0] dl;
  logic [stnl_pkg::MV_W-1:0] dc;
  logic [stnl_pkg::MV_W-1:0] dh;

  logic signed [stnl_pkg::DIV5_IN_W:0]   t9;
  logic [stnl_pkg::DIV5_IN_W-1:0]        t9_mag;
  logic [stnl_pkg::DIV5_PROD_W-1:0]      f_prod;
  logic                                  f_neg;
  logic [stnl_pkg::OUT_W-1:0]            f_q;
  logic signed [stnl_pkg::OUT_W:0]       f_s;
  logic signed [stnl_pkg::OUT_W:0]       f_val;

  function automatic logic [stnl_pkg::MV_W-1:0] absdiff(
    input logic [stnl_pkg::MV_W-1:0] a,
    input logic [stnl_pkg::MV_W-1:0] b
  );
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // effective entry count: zero acts as one, clamp to the table depth
  always_comb begin
    if (entries_in_use == '0) begin
      n_c = ONE;
    end else if (CW'(entries_in_use) > DEPTH_C) begin
      n_c = DEPTH_C;
    end else begin
      n_c = CW'(entries_in_use);
    end
  end

  assign first_mid = (n_c - ONE) >>> 1;

  assign rd_mv = ram_rdata[stnl_pkg::MV_W-1:0];
  assign rd_t  = ram_rdata[stnl_pkg::ENTRY_W-1:stnl_pkg::MV_W];
  assign rd_gt = (rd_mv > mv);

  assign lo_next  = rd_gt ? (mid + ONE) : lo;
  assign hi_next  = rd_gt ? hi : (mid - ONE);
  assign mid_next = lo_next + ((hi_next - lo_next) >>> 1);

  assign sts.hit        = (rd_mv == mv);
  assign sts.search_end = (lo_next > hi_next);

  assign below = (mid > ZERO) ? (mid - ONE) : ZERO;
  assign above = (mid < n_m1) ? (mid + ONE) : n_m1;

  // read address is issued in the cycle before the data it returns
  always_comb begin
    ram_raddr = mid[AW-1:0];
    if (cmd.init) begin
      ram_raddr = first_mid[AW-1:0];
    end else if (cmd.search) begin
      ram_raddr = sts.search_end ? below[AW-1:0] : mid_next[AW-1:0];
    end else if (cmd.nb_low) begin
      ram_raddr = above[AW-1:0];
    end
  end

  assign dl = absdiff(mv, l_mv);
  assign dc = absdiff(mv, c_mv);
  assign dh = absdiff(mv, h_mv);

  // ties: lower neighbor, then center, then upper neighbor
  always_comb begin
    if (dl <= dc && dl <= dh) begin
      t_pick = l_t;
    end else if (dc <= dh) begin
      t_pick = c_t;
    end else begin
      t_pick = h_t;
    end
  end

  assign t9     = ((stnl_pkg::DIV5_IN_W+1)'(t_sel) <<< 3) + (stnl_pkg::DIV5_IN_W+1)'(t_sel);
  assign t9_mag = t9[stnl_pkg::DIV5_IN_W] ? stnl_pkg::DIV5_IN_W'(-t9)
                                          : stnl_pkg::DIV5_IN_W'(t9);

  assign f_q   = f_prod[stnl_pkg::DIV5_SHIFT +: stnl_pkg::OUT_W];
  assign f_s   = f_neg ? -$signed({1'b0, f_q}) : $signed({1'b0, f_q});
  assign f_val = f_s + stnl_pkg::F_OFFSET;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample <= adc_sample;
    end
    if (cmd.scale) begin
      mv_prod <= stnl_pkg::MV_PROD_W'(sample) * stnl_pkg::MV_PROD_W'(stnl_pkg::MV_MUL);
    end
    if (cmd.init) begin
      mv   <= mv_prod[stnl_pkg::MV_SHIFT +: stnl_pkg::MV_W];
      lo   <= ZERO;
      hi   <= n_c - ONE;
      mid  <= first_mid;
      n_m1 <= n_c - ONE;
    end
    if (cmd.search) begin
      if (sts.hit) begin
        t_sel <= rd_t;
      end else if (sts.search_end) begin
        c_mv <= rd_mv;
        c_t  <= rd_t;
      end else begin
        lo  <= lo_next;
        hi  <= hi_next;
        mid <= mid_next;
      end
    end
    if (cmd.nb_low) begin
      l_mv <= rd_mv;
      l_t  <= rd_t;
    end
    if (cmd.nb_high) begin
      h_mv <= rd_mv;
      h_t  <= rd_t;
    end
    if (cmd.pick) begin
      t_sel <= t_pick;
    end
    if (cmd.fmul) begin
      f_prod <= stnl_pkg::DIV5_PROD_W'(t9_mag) * stnl_pkg::DIV5_PROD_W'(stnl_pkg::DIV5_MUL);
      f_neg  <= t9[stnl_pkg::DIV5_IN_W];
    end
    if (cmd.fout) begin
      if (unit_select == stnl_pkg::UNIT_FAHRENHEIT) begin
        temperature <= f_val[stnl_pkg::OUT_W-1:0];
      end else begin
        temperature <= stnl_pkg::OUT_W'(t_sel);
      end
    end
  end

`ifndef SYNTHESIS
  a_probe_in_window: assert property (@(posedge clk)
    cmd.search |-> (mid >= lo && mid <= hi && mid >= ZERO && mid <= n_m1))
    else $error("probe index outside search window");
`endif

endmodule

### rtl/core/sensor_table_nearest_linearizer_top.sv
// ----------------------------------------------------------------------------
// sensor_table_nearest_linearizer_top
// Calibration table lookup: ADC sample to nearest table temperature.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a word is taken at a rising edge with start high and
//   busy low. kind selects a table load (entry_index, entry_temperature,
//   entry_millivolts) or a convert (adc_sample).
//   A load is written into the table at the accepting edge; busy stays low,
//   so loads can follow each other every cycle. Loads past the table depth
//   are dropped.
//   A convert raises busy and yields one result word: temperature is valid
//   while done is high, for exactly one cycle. It scales, starts a binary
//   search at one table read per cycle (at most 9 probes for 256 entries),
//   reads both neighbors and picks the nearest, then applies the unit; an
//   exact hit skips the neighbors. Busy falls in the cycle done shows.
//   Result receiver cannot stall; done is a strobe.
//   Config: APB port, unit_select at 0x0, entries_in_use at 0x4, to be
//   written only while idle by the user; the block does not enforce it.
//   Reset (rst, synchronous): sequencer idle, Fahrenheit, 201 entries. The
//   table itself is not cleared and must be loaded before converting.
// ----------------------------------------------------------------------------
module sensor_table_nearest_linearizer_top #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                kind,
  input  logic [stnl_pkg::IDX_W-1:0]          entry_index,
  input  logic signed [stnl_pkg::TEMP_W-1:0]  entry_temperature,
  input  logic [stnl_pkg::MV_W-1:0]           entry_millivolts,
  input  logic [stnl_pkg::SAMPLE_W-1:0]       adc_sample,
  output logic                                done,
  output logic signed [stnl_pkg::OUT_W-1:0]   temperature,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic                         unit_select;
  logic [stnl_pkg::ENT_W-1:0]   entries_in_use;
  logic                         cfg_wr;

  stnl_pkg::cmd_t               cmd;
  stnl_pkg::sts_t               sts;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [AW-1:0]                ram_raddr;
  logic [stnl_pkg::ENTRY_W-1:0] ram_wdata;
  logic [stnl_pkg::ENTRY_W-1:0] ram_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_select    <= stnl_pkg::UNIT_RESET;
      entries_in_use <= stnl_pkg::ENTRIES_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        stnl_pkg::REG_UNIT:    unit_select    <= pwdata[0];
        stnl_pkg::REG_ENTRIES: entries_in_use <= pwdata[stnl_pkg::ENT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      stnl_pkg::REG_UNIT:    prdata = 32'(unit_select);
      stnl_pkg::REG_ENTRIES: prdata = 32'(entries_in_use);
      default:               prdata = '0;
    endcase
  end

  // table load happens at the accepting edge
  assign ram_we    = start && !busy && (kind == stnl_pkg::KIND_LOAD)
                     && (32'(entry_index) < TABLE_DEPTH);
  assign ram_waddr = AW'(entry_index);
  assign ram_wdata = {entry_temperature, entry_millivolts};

  stnl_ram #(
    .WIDTH (stnl_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  stnl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  stnl_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .unit_select    (unit_select),
    .entries_in_use (entries_in_use),
    .adc_sample     (adc_sample),
    .sts            (sts),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .temperature    (temperature)
  );

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_convert_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind == stnl_pkg::KIND_CONVERT) |=> (busy && !done))
    else $error("convert accepted without entering the busy phase");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while a convert is still running");
`endif

endmodule
